// File: src/lsb_stego_embed_extract_defines.svh
// Assertion macros for the steganography block
`ifndef LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset
`define LSBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lsbs: assertion failed");
// Checked on every edge, reset included
`define LSBS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lsbs: reset assertion failed");
`else
`define LSBS_ASSERT(label, prop)
`define LSBS_ASSERT_RST(label, prop)
`endif

`endif

// File: src/lsbs_pkg.sv
package lsbs_pkg;

  localparam int HEADER_BITS = 32;
  localparam int CHANNELS    = 3;

  localparam int CHAN_W     = 8;
  localparam int LEN_W      = 32;
  localparam int FP_W       = 25;
  localparam int CNT_W      = 26;
  localparam int TOTAL_W    = FP_W + 2;
  localparam int CAP_W      = TOTAL_W - 3;
  localparam int LEN8_W     = LEN_W + 3;
  localparam int HDR_IDX_W  = $clog2(HEADER_BITS);
  localparam int BIT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [FP_W-1:0] FP_RESET = FP_W'(10000);

  typedef enum logic {
    MODE_EMBED,
    MODE_EXTRACT
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_MESSAGE_BYTES,
    REG_FRAME_PIXELS
  } reg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic [LEN_W-1:0]   message_bytes;
    logic [TOTAL_W-1:0] total;
    logic [CAP_W-1:0]   cap;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic              bit_taken;
    logic [CHAN_W-1:0] byte_out;
    logic              byte_valid;
    logic              size_error;
  } res_t;

  // Channels in a frame
  function automatic logic [TOTAL_W-1:0] total_of(input logic [FP_W-1:0] fp);
    return TOTAL_W'(fp) * TOTAL_W'(CHANNELS);
  endfunction

  // Payload capacity in bytes once the header is taken off
  function automatic logic [CAP_W-1:0] cap_of(input logic [TOTAL_W-1:0] total);
    logic [TOTAL_W-1:0] rest;
    rest = total - TOTAL_W'(HEADER_BITS);
    return rest[TOTAL_W-1:3];
  endfunction

endpackage

// File: src/lsbs_in_if.sv
interface lsbs_in_if;
  import lsbs_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_start;
  logic [CHAN_W-1:0] channel_value;
  logic              payload_bit;

  modport source (output valid, output frame_start, output channel_value,
                  output payload_bit, input ready);
  modport sink   (input valid, input frame_start, input channel_value,
                  input payload_bit, output ready);
endinterface

// File: src/lsbs_out_if.sv
interface lsbs_out_if;
  import lsbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_out;
  logic              bit_taken;
  logic [CHAN_W-1:0] byte_out;
  logic              byte_valid;
  logic              size_error;

  modport source (output valid, output channel_out, output bit_taken,
                  output byte_out, output byte_valid, output size_error,
                  input ready);
  modport sink   (input valid, input channel_out, input bit_taken,
                  input byte_out, input byte_valid, input size_error,
                  output ready);
endinterface

// File: src/lsb_stego_embed_extract.sv
// LSB steganography embed/extract, one 8-bit colour channel per word. A word
// is taken every clock while the result side keeps up, and its result passes
// through the input register and then the result register before it leaves.
// The frame counters and byte packer update once per word, which is the loop
// that holds the rate at one word a clock.
// There is no start-up pass; the block takes words from the first cycle after
// reset. Configuration writes are meant for idle periods between frames.
`include "lsb_stego_embed_extract_defines.svh"

module lsb_stego_embed_extract (
  input  logic                            clk,
  input  logic                            rst_n,
  lsbs_in_if.sink                         in_ch,
  lsbs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lsbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lsbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsbs_pkg::*;

  cfg_t              cfg;
  res_t              res;
  res_t              res_r;
  logic              s1_valid_r;
  logic              s1_start_r;
  logic [CHAN_W-1:0] s1_chan_r;
  logic              s1_pbit_r;
  logic              out_valid_r;
  logic              s1_adv;
  logic              in_acc;

  lsbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsbs_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_adv),
    .frame_start   (s1_start_r),
    .channel_value (s1_chan_r),
    .payload_bit   (s1_pbit_r),
    .cfg           (cfg),
    .res           (res)
  );

  // Advance when the result register is empty or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start_r <= in_ch.frame_start;
      s1_chan_r  <= in_ch.channel_value;
      s1_pbit_r  <= in_ch.payload_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = res_r.channel_out;
  assign out_ch.bit_taken   = res_r.bit_taken;
  assign out_ch.byte_out    = res_r.byte_out;
  assign out_ch.byte_valid  = res_r.byte_valid;
  assign out_ch.size_error  = res_r.size_error;

  `LSBS_ASSERT_RST(a_reset_empties, (!rst_n |=> !out_valid_r && !s1_valid_r))
  `LSBS_ASSERT(a_stalled_word_held, (s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_chan_r)))
  `LSBS_ASSERT(a_embed_extract_apart, (out_valid_r && res_r.bit_taken |-> !res_r.byte_valid && !res_r.size_error))
  `LSBS_ASSERT(a_byte_zero_when_idle, (out_valid_r && !res_r.byte_valid |-> res_r.byte_out == '0))

endmodule

// File: src/lsbs_cfg.sv
module lsbs_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lsbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lsbs_pkg::cfg_t                  cfg
);
  import lsbs_pkg::*;

  mode_t              mode_r;
  logic [LEN_W-1:0]   msg_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CAP_W-1:0]   cap_r;
  logic [TOTAL_W-1:0] total_wr;

  // Frame size is kept as channel count and byte capacity, worked out on write
  assign total_wr = total_of(cfg_wdata[FP_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EMBED;
      msg_r   <= '0;
      total_r <= total_of(FP_RESET);
      cap_r   <= cap_of(total_of(FP_RESET));
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_MODE:          mode_r <= mode_t'(cfg_wdata[0]);
        REG_MESSAGE_BYTES: msg_r  <= cfg_wdata[LEN_W-1:0];
        REG_FRAME_PIXELS: begin
          total_r <= total_wr;
          cap_r   <= cap_of(total_wr);
        end
        default: ;
      endcase
    end
  end

  assign cfg.mode          = mode_r;
  assign cfg.message_bytes = msg_r;
  assign cfg.total         = total_r;
  assign cfg.cap           = cap_r;

endmodule

// File: src/lsbs_core.sv
module lsbs_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        frame_start,
  input  logic [lsbs_pkg::CHAN_W-1:0] channel_value,
  input  logic                        payload_bit,
  input  lsbs_pkg::cfg_t              cfg,
  output lsbs_pkg::res_t              res
);
  import lsbs_pkg::*;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt;
  logic [LEN_W-1:0]     len_r, len_nxt, len;
  logic [CNT_W-1:0]     done_r, done_nxt, done;
  logic [CHAN_W-1:0]    bsh_r, bsh_nxt, bsh;
  logic [BIT_IDX_W-1:0] bib_r, bib_nxt, bib;
  logic                 stop_r, stop_nxt, stop;
  logic                 active;
  logic                 in_header;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [HDR_IDX_W-1:0] hdr_sh;

  always_comb begin
    // Start of frame clears the counters before this word is handled
    cnt  = frame_start ? '0 : cnt_r;
    len  = frame_start ? '0 : len_r;
    done = frame_start ? '0 : done_r;
    bsh  = frame_start ? '0 : bsh_r;
    bib  = frame_start ? '0 : bib_r;
    stop = frame_start ? 1'b0 : stop_r;

    cnt_nxt  = cnt;
    len_nxt  = len;
    done_nxt = done;
    bsh_nxt  = bsh;
    bib_nxt  = bib;
    stop_nxt = stop;

    active    = (TOTAL_W'(cnt) < cfg.total) && !(&cnt);
    in_header = cnt < CNT_W'(HEADER_BITS);
    hdr_idx   = cnt[HDR_IDX_W-1:0];
    hdr_sh    = HDR_IDX_W'(HEADER_BITS - 1) - hdr_idx;

    res             = '0;
    res.channel_out = channel_value;

    if (active) begin
      cnt_nxt = cnt + CNT_W'(1);
      if (cfg.mode == MODE_EMBED) begin
        if (in_header) begin
          res.channel_out = {channel_value[CHAN_W-1:1], cfg.message_bytes[hdr_sh]};
        end else if (LEN8_W'(done) < {cfg.message_bytes, 3'b000}) begin
          res.channel_out = {channel_value[CHAN_W-1:1], payload_bit};
          res.bit_taken   = 1'b1;
          done_nxt        = done + CNT_W'(1);
        end
      end else begin
        if (in_header) begin
          len_nxt = {len[LEN_W-2:0], channel_value[0]};
          // Length is complete on the last header bit: check it against capacity
          if (hdr_idx == HDR_IDX_W'(HEADER_BITS - 1) && len_nxt > LEN_W'(cfg.cap)) begin
            stop_nxt = 1'b1;
          end
        end else if (!stop && LEN8_W'(done) < {len, 3'b000}) begin
          bsh_nxt  = {bsh[CHAN_W-2:0], channel_value[0]};
          done_nxt = done + CNT_W'(1);
          if (&bib) begin
            res.byte_out   = bsh_nxt;
            res.byte_valid = 1'b1;
            bsh_nxt        = '0;
            bib_nxt        = '0;
          end else begin
            bib_nxt = bib + BIT_IDX_W'(1);
          end
        end
      end
    end

    res.size_error = (cfg.mode == MODE_EXTRACT) ? stop_nxt : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      len_r  <= '0;
      done_r <= '0;
      bsh_r  <= '0;
      bib_r  <= '0;
      stop_r <= 1'b0;
    end else if (advance) begin
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      done_r <= done_nxt;
      bsh_r  <= bsh_nxt;
      bib_r  <= bib_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lsbs_pkg::*;

  typedef enum int {
    PACE_NONE,
    PACE_LIGHT,
    PACE_HEAVY
  } pace_t;

  localparam int RANDOM_WORDS = 1750;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsbs_in_if  in_if ();
  lsbs_out_if out_if ();

  lsb_stego_embed_extract i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow registers and frame state of the block
  mode_t             cur_mode   = MODE_EMBED;
  logic [LEN_W-1:0]  cur_msg    = '0;
  logic [FP_W-1:0]   cur_pixels = FP_RESET;
  logic [CNT_W-1:0]  chan_idx   = '0;
  logic [LEN_W-1:0]  len_acc    = '0;
  logic [LEN8_W-1:0] bits_done  = '0;
  logic [7:0]        byte_acc   = '0;
  logic [2:0]        bit_pos    = '0;
  logic              halted     = 1'b0;

  res_t  stego_due[$];
  int    mismatches = 0;
  int    words_seen = 0;
  int    words_sent = 0;
  pace_t send_pace  = PACE_NONE;
  pace_t recv_pace  = PACE_NONE;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_draw(pace_t pace);
    int cycles;
    cycles = 0;
    case (pace)
      PACE_LIGHT: if ($urandom_range(0, 3) == 0) cycles = $urandom_range(0, 12);
      PACE_HEAVY: cycles = $urandom_range(0, 12);
      default:    cycles = 0;
    endcase
    return cycles;
  endfunction

  function automatic res_t predict_channel(logic fs, logic [7:0] cv, logic pb);
    res_t              r;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] cap;
    r = '0;
    r.channel_out = cv;
    total = TOTAL_W'(cur_pixels) * TOTAL_W'(CHANNELS);
    if (fs) begin
      chan_idx  = '0;
      len_acc   = '0;
      bits_done = '0;
      byte_acc  = '0;
      bit_pos   = '0;
      halted    = 1'b0;
    end
    if (TOTAL_W'(chan_idx) < total && chan_idx != {CNT_W{1'b1}}) begin
      if (cur_mode == MODE_EMBED) begin
        if (chan_idx < CNT_W'(HEADER_BITS)) begin
          r.channel_out = {cv[7:1], cur_msg[HEADER_BITS - 1 - int'(chan_idx)]};
        end else if (bits_done < {cur_msg, 3'b000}) begin
          r.channel_out = {cv[7:1], pb};
          r.bit_taken   = 1'b1;
          bits_done     = bits_done + LEN8_W'(1);
        end
      end else begin
        if (chan_idx < CNT_W'(HEADER_BITS)) begin
          len_acc = {len_acc[LEN_W-2:0], cv[0]};
          if (chan_idx == CNT_W'(HEADER_BITS - 1)) begin
            cap = (total - TOTAL_W'(HEADER_BITS)) >> 3;
            if (len_acc > LEN_W'(cap)) halted = 1'b1;
          end
        end else if (!halted && bits_done < {len_acc, 3'b000}) begin
          byte_acc  = {byte_acc[6:0], cv[0]};
          bits_done = bits_done + LEN8_W'(1);
          if (bit_pos == 3'd7) begin
            r.byte_out   = byte_acc;
            r.byte_valid = 1'b1;
            byte_acc     = '0;
            bit_pos      = '0;
          end else begin
            bit_pos = bit_pos + 3'd1;
          end
        end
      end
      chan_idx = chan_idx + CNT_W'(1);
    end
    r.size_error = (cur_mode == MODE_EXTRACT) ? halted : 1'b0;
    return r;
  endfunction

  task automatic send_channel(logic fs, logic [7:0] cv, logic pb);
    int gap;
    gap = idle_draw(send_pace);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.frame_start   <= fs;
    in_if.channel_value <= cv;
    in_if.payload_bit   <= pb;
    do @(posedge clk); while (!in_if.ready);
    stego_due.push_back(predict_channel(fs, cv, pb));
    words_sent++;
    @(negedge clk);
  endtask

  // Hold off until every result word is back and the pipeline is empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (stego_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_MODE:          cur_mode = value[0] ? MODE_EXTRACT : MODE_EMBED;
      REG_MESSAGE_BYTES: cur_msg = value;
      REG_FRAME_PIXELS:  cur_pixels = value[FP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_pass_through();
    write_reg(REG_FRAME_PIXELS, '0);
    send_channel(1'b1, 8'h00, 1'b0);
    send_channel(1'b0, 8'hFF, 1'b1);
    send_channel(1'b0, 8'h01, 1'b1);
    send_channel(1'b0, 8'hFE, 1'b0);
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_EXTRACT));
    send_channel(1'b1, 8'hFF, 1'b1);
    send_channel(1'b0, 8'h00, 1'b0);
    settle();
  endtask

  // Frames too short for a header never finish it in either mode
  task automatic test_short_frame();
    write_reg(REG_FRAME_PIXELS, 2);
    for (int i = 0; i < 8; i++) send_channel(i == 0, 8'($urandom), 1'($urandom));
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_EMBED));
    write_reg(REG_MESSAGE_BYTES, '1);
    for (int i = 0; i < 7; i++) send_channel(i == 0, 8'($urandom), 1'($urandom));
    settle();
  endtask

  // Widest frame, largest length; swap mode mid-frame without a restart
  task automatic test_large_frame();
    send_pace = PACE_LIGHT;
    recv_pace = PACE_LIGHT;
    write_reg(REG_FRAME_PIXELS, {FP_W{1'b1}});
    for (int i = 0; i < HEADER_BITS + 4; i++)
      send_channel(i == 0, 8'($urandom), 1'($urandom));
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_EXTRACT));
    for (int i = 0; i < 4; i++) send_channel(1'b0, 8'($urandom), 1'($urandom));
    settle();
  endtask

  task automatic random_frame();
    logic [FP_W-1:0]    pixels;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] cap;
    logic [LEN_W-1:0]   msg;
    logic [LEN_W-1:0]   hidden;
    logic [7:0]         cv;
    logic               fs;
    logic               lsb;
    mode_t              md;
    int                 pick;
    int                 n;
    int                 pos;
    int                 restart_at;
    int                 flip_at;
    send_pace = pace_t'($urandom_range(0, 2));
    recv_pace = pace_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 19);
    if (pick < 14)      pixels = FP_W'($urandom_range(11, 48));
    else if (pick < 17) pixels = FP_W'($urandom_range(0, 10));
    else                pixels = FP_W'($urandom_range(49, 160));
    total = TOTAL_W'(pixels) * TOTAL_W'(CHANNELS);
    cap   = (total >= TOTAL_W'(HEADER_BITS)) ? (total - TOTAL_W'(HEADER_BITS)) >> 3 : '0;
    md    = $urandom_range(0, 1) ? MODE_EXTRACT : MODE_EMBED;
    case ($urandom_range(0, 9))
      0:       msg = '0;
      1:       msg = '1;
      2:       msg = $urandom;
      default: msg = LEN_W'($urandom_range(0, int'(cap) + 1));
    endcase
    case ($urandom_range(0, 9))
      7:       hidden = LEN_W'(cap) + LEN_W'($urandom_range(1, 3));
      8:       hidden = $urandom;
      9:       hidden = '1;
      default: hidden = LEN_W'($urandom_range(0, int'(cap)));
    endcase
    write_reg(REG_MODE, CFG_DATA_W'(md));
    write_reg(REG_MESSAGE_BYTES, msg);
    write_reg(REG_FRAME_PIXELS, CFG_DATA_W'(pixels));
    n = int'(total);
    case ($urandom_range(0, 9))
      0: n = n + $urandom_range(1, 4);
      1: if (n > 0) n = n - $urandom_range(1, (n < 5) ? n : 5);
      default: ;
    endcase
    restart_at = ($urandom_range(0, 9) == 0 && n > 1) ? $urandom_range(1, n - 1) : -1;
    flip_at    = ($urandom_range(0, 9) == 0 && n > 1) ? $urandom_range(1, n - 1) : -1;
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if (i == flip_at) begin
        settle();
        md = (md == MODE_EMBED) ? MODE_EXTRACT : MODE_EMBED;
        write_reg(REG_MODE, CFG_DATA_W'(md));
      end
      fs = (i == 0) ? ($urandom_range(0, 4) != 0) : (i == restart_at);
      if (fs) pos = 0;
      lsb = (pos < HEADER_BITS) ? hidden[HEADER_BITS - 1 - pos] : 1'($urandom);
      cv  = {7'($urandom), lsb};
      send_channel(fs, cv, 1'($urandom));
      pos++;
    end
    settle();
  endtask

  task automatic test_random_frames();
    int first;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) random_frame();
  endtask

  always @(posedge clk) begin : check_words
    res_t got;
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.channel_out = out_if.channel_out;
      got.bit_taken   = out_if.bit_taken;
      got.byte_out    = out_if.byte_out;
      got.byte_valid  = out_if.byte_valid;
      got.size_error  = out_if.size_error;
      if (stego_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("word %0d: unexpected result out=%02h taken=%b byte=%02h/%b err=%b",
                   words_seen, got.channel_out, got.bit_taken, got.byte_out,
                   got.byte_valid, got.size_error);
        mismatches++;
      end else begin
        want = stego_due.pop_front();
        if (got.channel_out !== want.channel_out || got.bit_taken !== want.bit_taken ||
            got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
            got.size_error !== want.size_error) begin
          if (mismatches < MAX_REPORTS)
            $display({"word %0d: expected out=%02h taken=%b byte=%02h/%b err=%b, ",
                      "got out=%02h taken=%b byte=%02h/%b err=%b"},
                     words_seen, want.channel_out, want.bit_taken, want.byte_out,
                     want.byte_valid, want.size_error, got.channel_out, got.bit_taken,
                     got.byte_out, got.byte_valid, got.size_error);
          mismatches++;
        end
      end
      words_seen++;
    end
  end

  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_draw(recv_pace);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int guard;
    in_if.valid         = 1'b0;
    in_if.frame_start   = 1'b0;
    in_if.channel_value = '0;
    in_if.payload_bit   = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_MODE;
    cfg_wdata           = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pass_through();
    test_short_frame();
    test_large_frame();
    test_random_frames();

    in_if.valid <= 1'b0;
    guard = 0;
    while (stego_due.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    // count words that never came back
    mismatches += stego_due.size();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/lsbs_pkg.sv
src/lsbs_in_if.sv
src/lsbs_out_if.sv
src/lsbs_cfg.sv
src/lsbs_core.sv
src/lsb_stego_embed_extract.sv
tb/tb.sv
